>>> rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lprr_pkg.sv
package lprr_pkg;

  localparam int BYTE_W = 8;
  localparam int CMD_W  = 3;
  localparam int LEN_W  = 10;
  localparam int CAP_W  = 7;
  localparam int FREE_W = 11;
  localparam int STAT_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_BEGIN = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_DATA  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_OPEN = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic              last;
    logic [FREE_W-1:0] free_bytes;
    logic              is_empty;
  } result_t;

endpackage

>>> rtl/lprr_ram.sv
module lprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lprr_oreg.sv
module lprr_oreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lprr_pkg::result_t din,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output lprr_pkg::result_t dout
);

  import lprr_pkg::*;

  // slot can take a new result when empty or draining this cycle
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

>>> rtl/length_prefixed_record_ring.sv
// push_data, clear, unused codes, a refused push_begin and pop or peek of an empty ring stay in S_IDLE
// an accepted push_begin writes the header in S_WHDR, one header byte per cycle on the ram port
// pop and peek of a record go through S_RHDR, S_CALC, then S_BYTES or S_ZERO, one ram read per byte
// output stalls hold S_BYTES and S_ZERO; the next transfer waits for idle and a free output slot
// a result is registered and shows in the cycle after its transfer; pop or peek bytes follow the header reads
// synchronous active-high reset empties the ring; ram not cleared, only reserved bytes are read
`include "assert_macros.svh"

module length_prefixed_record_ring #(
  parameter int RING_BYTES = 1024,
  parameter int HDR_BYTES  = 2,
  parameter int MAX_READ   = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lprr_pkg::CMD_W-1:0]    cmd,
  input  logic [lprr_pkg::LEN_W-1:0]    record_len,
  input  logic [lprr_pkg::BYTE_W-1:0]   data_byte,
  input  logic [lprr_pkg::CAP_W-1:0]    reader_cap,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lprr_pkg::STAT_W-1:0]   status,
  output logic [lprr_pkg::BYTE_W-1:0]   read_byte,
  output logic                          byte_valid,
  output logic                          last,
  output logic [lprr_pkg::FREE_W-1:0]   free_bytes,
  output logic                          is_empty
);

  import lprr_pkg::*;

  localparam int IW  = $clog2(RING_BYTES);
  localparam int SW  = $clog2(RING_BYTES + 1);
  localparam int CW  = ((SW > LEN_W) ? SW : LEN_W) + 1;
  localparam int HCW = $clog2(HDR_BYTES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // takes transfers
  localparam logic [2:0] S_WHDR  = 3'd1;  // writing the length header
  localparam logic [2:0] S_RHDR  = 3'd2;  // reading the length header
  localparam logic [2:0] S_CALC  = 3'd3;  // byte count and pop bookkeeping
  localparam logic [2:0] S_BYTES = 3'd4;  // streaming record bytes
  localparam logic [2:0] S_ZERO  = 3'd5;  // single result, no bytes

  // ring pointers and occupancy
  logic [2:0]       state, state_next;
  logic [IW-1:0]    read_index, read_index_next;
  logic [IW-1:0]    commit_index, commit_index_next;
  logic [IW-1:0]    write_index, write_index_next;
  logic [SW-1:0]    space_left, space_left_next;
  logic [SW-1:0]    record_count, record_count_next;
  logic [LEN_W-1:0] bytes_pending, bytes_pending_next;
  logic             push_open, push_open_next;

  // per-command working registers
  logic [LEN_W-1:0] open_len, open_len_next;
  logic             hdr_commit, hdr_commit_next;
  logic [HCW-1:0]   hcnt, hcnt_next;
  logic [IW-1:0]    rd_ptr, rd_ptr_next;
  logic [LEN_W-1:0] rlen, rlen_next;
  logic [CAP_W-1:0] ncap, ncap_next;
  logic [CAP_W-1:0] nbytes, nbytes_next;
  logic [CAP_W-1:0] kcnt, kcnt_next;
  logic             is_pop, is_pop_next;

  // ram port
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // output register side
  logic    slot_free;
  logic    res_load;
  result_t res_d;
  result_t res_q;

  logic accept;

  // push_begin arithmetic: an open record is dropped first, then the new one checked
  logic [CW-1:0] sl_drop;
  logic [CW-1:0] need;
  logic          len_fits;
  logic          begin_ok;
  logic [CW-1:0] sl_after_begin;

  // pop arithmetic on the registered header length
  logic [CW-1:0]    rd_sum;
  logic [CW-1:0]    sl_sum;
  logic [CAP_W-1:0] nb;
  logic [BYTE_W-1:0] hdr_byte;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
    return (i == IW'(RING_BYTES - 1)) ? '0 : i + 1'b1;
  endfunction

  lprr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lprr_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .din       (res_d),
    .ready     (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_q)
  );

  assign status     = res_q.status;
  assign read_byte  = res_q.read_byte;
  assign byte_valid = res_q.byte_valid;
  assign last       = res_q.last;
  assign free_bytes = res_q.free_bytes;
  assign is_empty   = res_q.is_empty;

  // a transfer is taken only when idle and the output slot can hold its result
  assign in_stall = !(state == S_IDLE && slot_free);
  assign accept   = in_valid && !in_stall;

  assign sl_drop  = CW'(space_left)
                  + (push_open ? (CW'(open_len) + CW'(HDR_BYTES)) : '0);
  assign need     = CW'(record_len) + CW'(HDR_BYTES);
  // length must be representable in the header
  assign len_fits = (HDR_BYTES >= 2) || (record_len[LEN_W-1:BYTE_W] == '0);
  assign begin_ok = len_fits && (need <= sl_drop);
  assign sl_after_begin = begin_ok ? (sl_drop - need) : sl_drop;

  assign rd_sum = CW'(read_index) + CW'(rlen) + CW'(HDR_BYTES);
  assign sl_sum = CW'(space_left) + CW'(rlen) + CW'(HDR_BYTES);
  assign nb     = (LEN_W'(ncap) > rlen) ? rlen[CAP_W-1:0] : ncap;

  // little-endian header, only the low two bytes can be non-zero
  always_comb begin
    if (hcnt == '0) begin
      hdr_byte = open_len[BYTE_W-1:0];
    end else if (hcnt == HCW'(1)) begin
      hdr_byte = BYTE_W'(open_len[LEN_W-1:BYTE_W]);
    end else begin
      hdr_byte = '0;
    end
  end

  always_comb begin
    state_next         = state;
    read_index_next    = read_index;
    commit_index_next  = commit_index;
    write_index_next   = write_index;
    space_left_next    = space_left;
    record_count_next  = record_count;
    bytes_pending_next = bytes_pending;
    push_open_next     = push_open;
    open_len_next      = open_len;
    hdr_commit_next    = hdr_commit;
    hcnt_next          = hcnt;
    rd_ptr_next        = rd_ptr;
    rlen_next          = rlen;
    ncap_next          = ncap;
    nbytes_next        = nbytes;
    kcnt_next          = kcnt;
    is_pop_next        = is_pop;

    ram_we    = 1'b0;
    ram_waddr = write_index;
    ram_wdata = hdr_byte;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr;

    res_load         = 1'b0;
    res_d.status     = ST_OK;
    res_d.read_byte  = '0;
    res_d.byte_valid = 1'b0;
    res_d.last       = 1'b1;
    res_d.free_bytes = FREE_W'(space_left);
    res_d.is_empty   = (record_count == '0);

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (cmd)
            CMD_PUSH_BEGIN: begin
              // drop any open record, rewind to the last commit
              push_open_next     = 1'b0;
              bytes_pending_next = '0;
              write_index_next   = commit_index;
              space_left_next    = SW'(sl_after_begin);
              if (begin_ok) begin
                open_len_next = record_len;
                hcnt_next     = '0;
                state_next    = S_WHDR;
                if (record_len == '0) begin
                  // empty payload commits once the header is down
                  record_count_next = record_count + 1'b1;
                  hdr_commit_next   = 1'b1;
                end else begin
                  bytes_pending_next = record_len;
                  push_open_next     = 1'b1;
                  hdr_commit_next    = 1'b0;
                end
              end else begin
                res_d.status = ST_FULL;
              end
            end
            CMD_PUSH_DATA: begin
              if (!push_open) begin
                res_d.status = ST_NO_OPEN;
              end else begin
                ram_we             = 1'b1;
                ram_wdata          = data_byte;
                write_index_next   = wrap_inc(write_index);
                bytes_pending_next = bytes_pending - 1'b1;
                if (bytes_pending == LEN_W'(1)) begin
                  // last byte makes the record visible
                  commit_index_next = wrap_inc(write_index);
                  record_count_next = record_count + 1'b1;
                  push_open_next    = 1'b0;
                end
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (record_count == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                // results come later, after the header has been read
                res_load    = 1'b0;
                ram_re      = 1'b1;
                ram_raddr   = read_index;
                rd_ptr_next = wrap_inc(read_index);
                hcnt_next   = '0;
                is_pop_next = (cmd == CMD_POP);
                ncap_next   = (reader_cap > CAP_W'(MAX_READ)) ? CAP_W'(MAX_READ)
                                                              : reader_cap;
                state_next  = S_RHDR;
              end
            end
            CMD_CLEAR: begin
              read_index_next    = '0;
              commit_index_next  = '0;
              write_index_next   = '0;
              space_left_next    = SW'(RING_BYTES);
              record_count_next  = '0;
              bytes_pending_next = '0;
              push_open_next     = 1'b0;
            end
            default: begin
              // unused codes leave the ring as it is
            end
          endcase
          res_d.free_bytes = FREE_W'(space_left_next);
          res_d.is_empty   = (record_count_next == '0);
        end
      end

      S_WHDR: begin
        ram_we           = 1'b1;
        write_index_next = wrap_inc(write_index);
        if (hcnt == HCW'(HDR_BYTES - 1)) begin
          state_next = S_IDLE;
          if (hdr_commit) begin
            commit_index_next = wrap_inc(write_index);
          end
        end else begin
          hcnt_next = hcnt + 1'b1;
        end
      end

      S_RHDR: begin
        if (hcnt == '0) begin
          rlen_next = LEN_W'(ram_rdata);
        end else if (hcnt == HCW'(1)) begin
          rlen_next = {ram_rdata[LEN_W-BYTE_W-1:0], rlen[BYTE_W-1:0]};
        end
        if (hcnt == HCW'(HDR_BYTES - 1)) begin
          state_next = S_CALC;
        end else begin
          ram_re      = 1'b1;
          rd_ptr_next = wrap_inc(rd_ptr);
          hcnt_next   = hcnt + 1'b1;
        end
      end

      S_CALC: begin
        nbytes_next = nb;
        kcnt_next   = '0;
        if (is_pop) begin
          // free the whole record, header included
          read_index_next   = (rd_sum >= CW'(RING_BYTES)) ? IW'(rd_sum - CW'(RING_BYTES))
                                                          : IW'(rd_sum);
          space_left_next   = (sl_sum > CW'(RING_BYTES)) ? SW'(RING_BYTES) : SW'(sl_sum);
          record_count_next = record_count - 1'b1;
        end
        if (nb == '0) begin
          state_next = S_ZERO;
        end else begin
          ram_re      = 1'b1;
          rd_ptr_next = wrap_inc(rd_ptr);
          state_next  = S_BYTES;
        end
      end

      S_ZERO: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_BYTES: begin
        // ram data holds while the output slot is busy
        if (slot_free) begin
          res_load         = 1'b1;
          res_d.read_byte  = ram_rdata;
          res_d.byte_valid = 1'b1;
          res_d.last       = ((kcnt + 1'b1) == nbytes);
          if ((kcnt + 1'b1) == nbytes) begin
            state_next = S_IDLE;
          end else begin
            kcnt_next   = kcnt + 1'b1;
            ram_re      = 1'b1;
            rd_ptr_next = wrap_inc(rd_ptr);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      read_index    <= '0;
      commit_index  <= '0;
      write_index   <= '0;
      space_left    <= SW'(RING_BYTES);
      record_count  <= '0;
      bytes_pending <= '0;
      push_open     <= 1'b0;
    end else begin
      state         <= state_next;
      read_index    <= read_index_next;
      commit_index  <= commit_index_next;
      write_index   <= write_index_next;
      space_left    <= space_left_next;
      record_count  <= record_count_next;
      bytes_pending <= bytes_pending_next;
      push_open     <= push_open_next;
    end
  end

  always_ff @(posedge clk) begin
    open_len   <= open_len_next;
    hdr_commit <= hdr_commit_next;
    hcnt       <= hcnt_next;
    rd_ptr     <= rd_ptr_next;
    rlen       <= rlen_next;
    ncap       <= ncap_next;
    nbytes     <= nbytes_next;
    kcnt       <= kcnt_next;
    is_pop     <= is_pop_next;
  end

  // reads and writes never overlap: the read phases keep the write port quiet
  `ASSERT_NOW(a_no_write_in_read, clk, rst,
    (state == S_RHDR || state == S_CALC || state == S_BYTES || state == S_ZERO),
    !ram_we, "ring written during a read phase")
  `ASSERT_NOW(a_space_bound, clk, rst, 1'b1, space_left <= SW'(RING_BYTES),
    "free space above ring size")
  `ASSERT_NOW(a_open_pending, clk, rst, state == S_IDLE,
    push_open == (bytes_pending != '0), "open record and pending count disagree")
  `ASSERT_NEXT(a_last_ends, clk, rst, (state == S_BYTES && res_load && res_d.last),
    state == S_IDLE, "byte stream did not end on last")

endmodule

>>> sim/tb_length_prefixed_record_ring.sv
module tb_length_prefixed_record_ring;
  import lprr_pkg::*;

  localparam int RING_BYTES   = 1024;
  localparam int HDR_BYTES    = 2;
  localparam int MAX_READ     = 64;
  // watchdog and tail wait, in clock cycles
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 4 * (HDR_BYTES + 2 + MAX_READ);
  // long receiver hold-off so the block backs up into its input
  localparam int HOLD_CYCLES  = 400;

  // command codes the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic [CAP_W-1:0]  cap;
  } ring_op_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  cmd        = CMD_CLEAR;
  logic [LEN_W-1:0]  record_len = '0;
  logic [BYTE_W-1:0] data_byte  = '0;
  logic [CAP_W-1:0]  reader_cap = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] read_byte;
  logic              byte_valid;
  logic              last;
  logic [FREE_W-1:0] free_bytes;
  logic              is_empty;

  length_prefixed_record_ring #(
    .RING_BYTES(RING_BYTES),
    .HDR_BYTES (HDR_BYTES),
    .MAX_READ  (MAX_READ)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .record_len(record_len),
    .data_byte (data_byte),
    .reader_cap(reader_cap),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .read_byte (read_byte),
    .byte_valid(byte_valid),
    .last      (last),
    .free_bytes(free_bytes),
    .is_empty  (is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // commands waiting to be offered, and results the ring owes us
  ring_op_t ops_to_send[$];
  result_t  ring_results_due[$];

  int  cycle_count    = 0;
  int  ops_accepted   = 0;
  int  ops_total      = 0;
  int  fault_count    = 0;
  bit  offer_taken    = 1'b0;
  bit  hold_go        = 1'b0;
  int  hold_left      = 0;

  // shadow copy of the ring contents and pointers
  logic [BYTE_W-1:0] ring_mem [RING_BYTES];
  int unsigned rd_ptr;
  int unsigned cm_ptr;
  int unsigned wr_ptr;
  int unsigned space_free;
  int unsigned rec_count;
  int unsigned bytes_owed;
  bit          rec_open;

  // queue one result built from the post-step occupancy
  function automatic void owe_result(logic [STAT_W-1:0] st, logic [BYTE_W-1:0] b,
                                     logic v, logic l);
    result_t r;
    r.status     = st;
    r.read_byte  = b;
    r.byte_valid = v;
    r.last       = l;
    r.free_bytes = FREE_W'(space_free);
    r.is_empty   = (rec_count == 0);
    ring_results_due.push_back(r);
  endfunction

  function automatic void close_record();
    cm_ptr    = wr_ptr;
    rec_count = rec_count + 1;
    rec_open  = 1'b0;
  endfunction

  // what the ring must answer for one accepted command
  function automatic void predict_ring_step(ring_op_t op);
    logic [BYTE_W-1:0] taken [MAX_READ];
    int unsigned       len;
    int unsigned       idx;
    int unsigned       n;
    logic [STAT_W-1:0] st;
    len = op.len;
    case (op.cmd)
      CMD_PUSH_BEGIN: begin
        // an unfinished record gives back its whole reservation
        if (rec_open) begin
          space_free = space_free + ((wr_ptr + RING_BYTES - cm_ptr) % RING_BYTES) + bytes_owed;
          wr_ptr     = cm_ptr;
          rec_open   = 1'b0;
          bytes_owed = 0;
        end
        if ((len >> (8 * HDR_BYTES)) != 0 || len + HDR_BYTES > space_free) begin
          st = ST_FULL;
        end else begin
          // little-endian length header
          for (int i = 0; i < HDR_BYTES; i++) begin
            ring_mem[wr_ptr] = BYTE_W'(len >> (8 * i));
            wr_ptr = (wr_ptr + 1) % RING_BYTES;
          end
          space_free = space_free - (len + HDR_BYTES);
          bytes_owed = len;
          if (len == 0) close_record();
          else rec_open = 1'b1;
          st = ST_OK;
        end
        owe_result(st, '0, 1'b0, 1'b1);
      end
      CMD_PUSH_DATA: begin
        if (!rec_open) begin
          owe_result(ST_NO_OPEN, '0, 1'b0, 1'b1);
        end else begin
          ring_mem[wr_ptr] = op.data;
          wr_ptr     = (wr_ptr + 1) % RING_BYTES;
          bytes_owed = bytes_owed - 1;
          if (bytes_owed == 0) close_record();
          owe_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (rec_count == 0) begin
          owe_result(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          idx = rd_ptr;
          len = 0;
          for (int i = 0; i < HDR_BYTES; i++) begin
            len = len | (int'(ring_mem[idx]) << (8 * i));
            idx = (idx + 1) % RING_BYTES;
          end
          n = op.cap;
          if (n > MAX_READ) n = MAX_READ;
          if (n > len) n = len;
          for (int k = 0; k < n; k++) begin
            taken[k] = ring_mem[idx];
            idx = (idx + 1) % RING_BYTES;
          end
          // pop frees the whole record, not just the bytes handed out
          if (op.cmd == CMD_POP) begin
            rd_ptr     = (rd_ptr + len + HDR_BYTES) % RING_BYTES;
            space_free = space_free + len + HDR_BYTES;
            if (space_free > RING_BYTES) space_free = RING_BYTES;
            rec_count  = rec_count - 1;
          end
          if (n == 0) begin
            owe_result(ST_OK, '0, 1'b0, 1'b1);
          end else begin
            for (int k = 0; k < n; k++) owe_result(ST_OK, taken[k], 1'b1, k + 1 == n);
          end
        end
      end
      CMD_CLEAR: begin
        rd_ptr     = 0;
        cm_ptr     = 0;
        wr_ptr     = 0;
        space_free = RING_BYTES;
        rec_count  = 0;
        bytes_owed = 0;
        rec_open   = 1'b0;
        owe_result(ST_OK, '0, 1'b0, 1'b1);
      end
      default: begin
        owe_result(ST_OK, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  task automatic log_fault(string why, result_t want, result_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("mismatch (%s) at cycle %0d:", why, cycle_count);
      $display("  expected st=%0d byte=%02h bv=%0b last=%0b free=%0d empty=%0b",
               want.status, want.read_byte, want.byte_valid, want.last, want.free_bytes,
               want.is_empty);
      $display("  got      st=%0d byte=%02h bv=%0b last=%0b free=%0d empty=%0b",
               got.status, got.read_byte, got.byte_valid, got.last, got.free_bytes,
               got.is_empty);
    end
  endtask

  task automatic queue_op(logic [CMD_W-1:0] c, int len, int data, int cap);
    ring_op_t op;
    op.cmd  = c;
    op.len  = LEN_W'(len);
    op.data = BYTE_W'(data);
    op.cap  = CAP_W'(cap);
    ops_to_send.push_back(op);
  endtask

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("length_prefixed_record_ring regression: fail");
      $finish;
    end
  end

  // driver: bursts of transfers separated by random gaps, payload held while stalled
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : driver
    ring_op_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !offer_taken)) begin
      offer_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (ops_to_send.size() != 0) begin
        nxt = ops_to_send.pop_front();
        cmd        <= nxt.cmd;
        record_len <= nxt.len;
        data_byte  <= nxt.data;
        reader_cap <= nxt.cap;
        in_valid   <= 1'b1;
        // now and then a long burst with no idling at all
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
          gap_left   = $urandom_range(0, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, switching to a random mode when each run of it ends
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left  = 0;

  always @(negedge clk) begin : receiver
    bit want_stall;
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:  want_stall = 1'b0;
      STALL_LIGHT: want_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: want_stall = ($urandom_range(0, 3) != 0);
      default:     want_stall = (cycle_count % 3 == 0);
    endcase
    out_stall <= !rst && (want_stall || hold_left != 0);
  end

  // long hold-off, counted here on its own
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each result transfer, predict on each command transfer
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.status     = status;
        got.read_byte  = read_byte;
        got.byte_valid = byte_valid;
        got.last       = last;
        got.free_bytes = free_bytes;
        got.is_empty   = is_empty;
        if (ring_results_due.size() == 0) begin
          log_fault("unexpected result", '0, got);
        end else begin
          want = ring_results_due.pop_front();
          if (got.status !== want.status || got.read_byte !== want.read_byte ||
              got.byte_valid !== want.byte_valid || got.last !== want.last ||
              got.free_bytes !== want.free_bytes || got.is_empty !== want.is_empty)
            log_fault("field", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        offer_taken = 1'b1;
        ops_accepted++;
        predict_ring_step('{cmd, record_len, data_byte, reader_cap});
      end
    end
  end

  initial begin : stimulus
    int pick;
    int len;
    int cap;
    rd_ptr     = 0;
    cm_ptr     = 0;
    wr_ptr     = 0;
    space_free = RING_BYTES;
    rec_count  = 0;
    bytes_owed = 0;
    rec_open   = 1'b0;

    // directed: empty reads, stray data, zero-length and zero-cap reads
    queue_op(CMD_POP,        5, 8'h11, 10);
    queue_op(CMD_PUSH_DATA,  0, 8'h22, 0);
    queue_op(CMD_PUSH_BEGIN, 0, 8'h00, 64);
    queue_op(CMD_PEEK,       7, 8'h00, 5);
    queue_op(CMD_POP,        0, 8'hff, 64);
    queue_op(CMD_PUSH_BEGIN, 3, 8'h00, 0);
    queue_op(CMD_PUSH_DATA,  0, 8'h00, 0);
    queue_op(CMD_PUSH_DATA,  0, 8'hff, 0);
    queue_op(CMD_PUSH_DATA,  0, 8'h5a, 0);
    queue_op(CMD_PEEK,       0, 8'h00, 64);
    queue_op(CMD_POP,        0, 8'h00, 0);
    // whole-ring reservation, then restarted while still open
    queue_op(CMD_PUSH_BEGIN, 1022, 8'h00, 0);
    queue_op(CMD_PUSH_BEGIN, 4,    8'h00, 0);
    queue_op(CMD_PUSH_DATA,  0, 8'ha5, 0);
    queue_op(CMD_PUSH_DATA,  0, 8'h3c, 0);
    queue_op(CMD_PUSH_DATA,  0, 8'h81, 0);
    queue_op(CMD_PUSH_DATA,  0, 8'h7e, 0);
    // no room left: rejected, so following data has no open record
    queue_op(CMD_PUSH_BEGIN, 1022, 8'h00, 0);
    queue_op(CMD_PUSH_DATA,  0, 8'h99, 0);
    queue_op(CMD_POP,        0, 8'h00, 64);
    // clear with a record half written
    queue_op(CMD_PUSH_BEGIN, 10, 8'h00, 0);
    queue_op(CMD_PUSH_DATA,  0,  8'h42, 0);
    queue_op(CMD_CLEAR,      0,  8'h00, 0);
    queue_op(CMD_SPARE_5, 1023, 8'hff, 127);
    queue_op(CMD_SPARE_6, 0,    8'h00, 0);
    queue_op(CMD_SPARE_7, 512,  8'h80, 64);

    // random: mostly short complete records
    while (ops_to_send.size() < 100) begin
      pick = $urandom_range(0, 99);
      cap  = ($urandom_range(0, 3) == 0) ? MAX_READ : $urandom_range(0, MAX_READ);
      if (pick < 40) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
        queue_op(CMD_PUSH_BEGIN, len, $urandom_range(0, 255), cap);
        for (int k = 0; k < len; k++)
          queue_op(CMD_PUSH_DATA, $urandom_range(0, 1022), $urandom_range(0, 255), cap);
      end else if (pick < 65) begin
        queue_op(CMD_POP, $urandom_range(0, 1022), $urandom_range(0, 255), cap);
      end else if (pick < 75) begin
        queue_op(CMD_PEEK, $urandom_range(0, 1022), $urandom_range(0, 255), cap);
      end else if (pick < 90) begin
        // broken record: announced, then cut short
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1022) : $urandom_range(1, 20);
        queue_op(CMD_PUSH_BEGIN, len, $urandom_range(0, 255), cap);
        for (int k = $urandom_range(0, 5); k > 0; k--)
          queue_op(CMD_PUSH_DATA, $urandom_range(0, 1022), $urandom_range(0, 255), cap);
      end else if (pick < 95) begin
        queue_op(CMD_PUSH_DATA, $urandom_range(0, 1022), $urandom_range(0, 255), cap);
      end else if (pick < 99) begin
        case ($urandom_range(0, 2))
          0:       queue_op(CMD_SPARE_5, $urandom_range(0, 1022), $urandom_range(0, 255), cap);
          1:       queue_op(CMD_SPARE_6, $urandom_range(0, 1022), $urandom_range(0, 255), cap);
          default: queue_op(CMD_SPARE_7, $urandom_range(0, 1022), $urandom_range(0, 255), cap);
        endcase
      end else begin
        queue_op(CMD_CLEAR, $urandom_range(0, 1022), $urandom_range(0, 255), cap);
      end
    end
    ops_total = ops_to_send.size();

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // once traffic is flowing, starve the output long enough to back up the input
    wait (ops_accepted >= 60);
    @(negedge clk);
    hold_go = 1'b1;

    wait (ops_accepted == ops_total);
    wait (ring_results_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("length_prefixed_record_ring regression: pass");
    else
      $display("length_prefixed_record_ring regression: fail");
    $finish;
  end

endmodule
